// ----- rtl/bspc_pkg.sv -----
// Shared types, microcode encodings and constants of the BLDC speed PI controller.
`timescale 1ns / 1ps
`default_nettype none
package bspc_pkg;

   // Datapath operations, one per microcode step.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_MAP,
      OP_SPEED,
      OP_ERR,
      OP_MUL_KP,
      OP_MUL_KI,
      OP_ACC,
      OP_CLAMP,
      OP_SUM,
      OP_TRUNC,
      OP_DUTY,
      OP_OUT
   } op_type;

   // Sequencer branch conditions.
   typedef enum logic [2:0] {
      C_NEXT,
      C_WAIT_IN,
      C_OPEN,
      C_WAIT_OUT,
      C_JUMP
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ctrl_type;

   typedef struct packed {
      logic        closed;
      logic [15:0] duty;
      logic [15:0] speed;
   } status_type;

   // Microcode addresses.
   localparam upc_type STEP_FETCH = 4'd0;
   localparam upc_type STEP_MAP   = 4'd1;
   localparam upc_type STEP_SPEED = 4'd2;
   localparam upc_type STEP_ERR   = 4'd3;
   localparam upc_type STEP_KP    = 4'd4;
   localparam upc_type STEP_KI    = 4'd5;
   localparam upc_type STEP_ACC   = 4'd6;
   localparam upc_type STEP_CLAMP = 4'd7;
   localparam upc_type STEP_SUM   = 4'd8;
   localparam upc_type STEP_TRUNC = 4'd9;
   localparam upc_type STEP_DUTY  = 4'd10;
   localparam upc_type STEP_OUT   = 4'd11;

   // Register indexes.
   localparam logic [1:0] CSR_PWM_MAX      = 2'd0;
   localparam logic [1:0] CSR_PWM_MIN      = 2'd1;
   localparam logic [1:0] CSR_SPEED_TARGET = 2'd2;
   localparam logic [1:0] CSR_MAP_GAIN     = 2'd3;

   localparam logic [15:0] PWM_MAX_RESET      = 16'd1000;
   localparam logic [15:0] PWM_MIN_RESET      = 16'd50;
   localparam logic [15:0] SPEED_TARGET_RESET = 16'd800;
   localparam logic [23:0] MAP_GAIN_RESET     = 24'd991191;

   localparam logic [15:0] PERIOD_SLOWEST = 16'd17000;
   localparam logic [15:0] PERIOD_FASTEST = 16'd920;

   // 0.75 and 0.0021 in Q0.16.
   localparam logic signed [24:0] KP_Q16    = 25'sd49152;
   localparam logic signed [24:0] KI_DT_Q16 = 25'sd138;

endpackage
`default_nettype wire

// ----- rtl/bspc_rom.sv -----
// Control store: one control word per microcode step.
`timescale 1ns / 1ps
`default_nettype none
module bspc_rom (
   input  bspc_pkg::upc_type  upc,
   output bspc_pkg::ctrl_type ctrl
);

   always_comb begin
      unique case (upc)
         bspc_pkg::STEP_FETCH: begin
            ctrl = '{bspc_pkg::OP_LOAD, bspc_pkg::C_WAIT_IN, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_MAP: begin
            ctrl = '{bspc_pkg::OP_MUL_MAP, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         // Open loop skips the PI update and only reports.
         bspc_pkg::STEP_SPEED: begin
            ctrl = '{bspc_pkg::OP_SPEED, bspc_pkg::C_OPEN, bspc_pkg::STEP_OUT};
         end
         bspc_pkg::STEP_ERR: begin
            ctrl = '{bspc_pkg::OP_ERR, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_KP: begin
            ctrl = '{bspc_pkg::OP_MUL_KP, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_KI: begin
            ctrl = '{bspc_pkg::OP_MUL_KI, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_ACC: begin
            ctrl = '{bspc_pkg::OP_ACC, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_CLAMP: begin
            ctrl = '{bspc_pkg::OP_CLAMP, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_SUM: begin
            ctrl = '{bspc_pkg::OP_SUM, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_TRUNC: begin
            ctrl = '{bspc_pkg::OP_TRUNC, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_DUTY: begin
            ctrl = '{bspc_pkg::OP_DUTY, bspc_pkg::C_NEXT, bspc_pkg::STEP_FETCH};
         end
         bspc_pkg::STEP_OUT: begin
            ctrl = '{bspc_pkg::OP_OUT, bspc_pkg::C_WAIT_OUT, bspc_pkg::STEP_FETCH};
         end
         default: begin
            ctrl = '{bspc_pkg::OP_NOP, bspc_pkg::C_JUMP, bspc_pkg::STEP_FETCH};
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/bspc_datapath.sv -----
// Datapath of the speed PI controller: registers, one shared multiplier, adders and clamps.
`timescale 1ns / 1ps
`default_nettype none
module bspc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bspc_pkg::ctrl_type   ctrl,
   input  logic                 req_accept,
   input  logic [15:0]          req_period,
   input  logic                 req_closed,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_data,
   output bspc_pkg::status_type status
);

   logic [15:0]        pwm_max_ff, pwm_max_in;
   logic [15:0]        pwm_min_ff, pwm_min_in;
   logic [15:0]        speed_target_ff, speed_target_in;
   logic [23:0]        map_gain_ff, map_gain_in;

   logic [15:0]        period_ff, period_in;
   logic               closed_ff, closed_in;
   logic signed [42:0] prod_ff, prod_in;
   logic [15:0]        speed_ff, speed_in;
   logic signed [16:0] err_ff, err_in;
   logic signed [16:0] last_err_ff, last_err_in;
   logic signed [33:0] prop_ff, prop_in;
   logic signed [34:0] hi_ff, hi_in;
   logic signed [34:0] lo_ff, lo_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [31:0] trunc_ff, trunc_in;
   logic [15:0]        duty_ff, duty_in;

   logic [15:0]        period_eff;
   logic [13:0]        span;
   logic signed [17:0] err_pair;
   logic signed [17:0] mul_a;
   logic signed [24:0] mul_b;
   logic [16:0]        speed_sum;
   logic signed [34:0] maxq, minq, prop_ext;
   logic signed [47:0] hi_ext, lo_ext, sum_round;
   logic signed [32:0] trunc_ext, min_ext, max_ext, low_clamped;

   // Out-of-range periods pin the speed at either end of the mapping.
   always_comb begin
      if ((period_ff == 16'd0) || (period_ff > bspc_pkg::PERIOD_SLOWEST)) begin
         period_eff = bspc_pkg::PERIOD_SLOWEST;
      end else if (period_ff < bspc_pkg::PERIOD_FASTEST) begin
         period_eff = bspc_pkg::PERIOD_FASTEST;
      end else begin
         period_eff = period_ff;
      end
   end

   assign span     = 14'(bspc_pkg::PERIOD_SLOWEST - period_eff);
   assign err_pair = $signed({err_ff[16], err_ff}) + $signed({last_err_ff[16], last_err_ff});

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (ctrl.op)
         bspc_pkg::OP_MUL_MAP: begin
            mul_a = $signed({4'b0, span});
            mul_b = $signed({1'b0, map_gain_ff});
         end
         bspc_pkg::OP_MUL_KP: begin
            mul_a = $signed({err_ff[16], err_ff});
            mul_b = bspc_pkg::KP_Q16;
         end
         bspc_pkg::OP_MUL_KI: begin
            mul_a = err_pair;
            mul_b = bspc_pkg::KI_DT_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign speed_sum = {3'b0, prod_ff[37:24]} + {1'b0, pwm_min_ff};
   assign maxq      = $signed({3'b0, pwm_max_ff, 16'b0});
   assign minq      = $signed({3'b0, pwm_min_ff, 16'b0});
   assign prop_ext  = $signed({prop_ff[33], prop_ff});
   assign hi_ext    = $signed({{13{hi_ff[34]}}, hi_ff});
   assign lo_ext    = $signed({{13{lo_ff[34]}}, lo_ff});
   // Adding 2^16-1 before the shift makes negative values round toward zero.
   assign sum_round = sum_ff + (sum_ff[47] ? 48'sd65535 : 48'sd0);
   assign trunc_ext = $signed({trunc_ff[31], trunc_ff});
   assign min_ext   = $signed({17'b0, pwm_min_ff});
   assign max_ext   = $signed({17'b0, pwm_max_ff});
   assign low_clamped = (trunc_ext < min_ext) ? min_ext : trunc_ext;

   always_comb begin
      pwm_max_in      = pwm_max_ff;
      pwm_min_in      = pwm_min_ff;
      speed_target_in = speed_target_ff;
      map_gain_in     = map_gain_ff;
      period_in       = period_ff;
      closed_in       = closed_ff;
      prod_in         = prod_ff;
      speed_in        = speed_ff;
      err_in          = err_ff;
      last_err_in     = last_err_ff;
      prop_in         = prop_ff;
      hi_in           = hi_ff;
      lo_in           = lo_ff;
      acc_in          = acc_ff;
      sum_in          = sum_ff;
      trunc_in        = trunc_ff;
      duty_in         = duty_ff;

      if (csr_write) begin
         unique case (csr_index)
            bspc_pkg::CSR_PWM_MAX:      pwm_max_in      = csr_data[15:0];
            bspc_pkg::CSR_PWM_MIN:      pwm_min_in      = csr_data[15:0];
            bspc_pkg::CSR_SPEED_TARGET: speed_target_in = csr_data[15:0];
            bspc_pkg::CSR_MAP_GAIN:     map_gain_in     = csr_data;
            default: ;
         endcase
      end

      unique case (ctrl.op)
         bspc_pkg::OP_LOAD: begin
            if (req_accept) begin
               period_in = req_period;
               closed_in = req_closed;
            end
         end
         bspc_pkg::OP_MUL_MAP: begin
            prod_in = mul_a * mul_b;
         end
         bspc_pkg::OP_SPEED: begin
            speed_in = speed_sum[16] ? 16'hFFFF : speed_sum[15:0];
         end
         bspc_pkg::OP_ERR: begin
            err_in = $signed({1'b0, speed_target_ff}) - $signed({1'b0, speed_ff});
         end
         bspc_pkg::OP_MUL_KP: begin
            prod_in = mul_a * mul_b;
         end
         bspc_pkg::OP_MUL_KI: begin
            prop_in = prod_ff[33:0];
            prod_in = mul_a * mul_b;
         end
         bspc_pkg::OP_ACC: begin
            acc_in      = acc_ff + $signed({{5{prod_ff[42]}}, prod_ff});
            last_err_in = err_ff;
            hi_in       = (maxq > prop_ext) ? (maxq - prop_ext) : 35'sd0;
            lo_in       = (minq < prop_ext) ? (minq - prop_ext) : 35'sd0;
         end
         bspc_pkg::OP_CLAMP: begin
            if (acc_ff > hi_ext) begin
               acc_in = hi_ext;
            end else if (acc_ff < lo_ext) begin
               acc_in = lo_ext;
            end
         end
         bspc_pkg::OP_SUM: begin
            sum_in = acc_ff + $signed({{14{prop_ff[33]}}, prop_ff});
         end
         bspc_pkg::OP_TRUNC: begin
            trunc_in = sum_round[47:16];
         end
         bspc_pkg::OP_DUTY: begin
            // The upper limit is applied last, so it wins when the limits cross.
            duty_in = (low_clamped > max_ext) ? pwm_max_ff : low_clamped[15:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_max_ff      <= bspc_pkg::PWM_MAX_RESET;
         pwm_min_ff      <= bspc_pkg::PWM_MIN_RESET;
         speed_target_ff <= bspc_pkg::SPEED_TARGET_RESET;
         map_gain_ff     <= bspc_pkg::MAP_GAIN_RESET;
         acc_ff          <= '0;
         last_err_ff     <= '0;
         duty_ff         <= '0;
      end else begin
         pwm_max_ff      <= pwm_max_in;
         pwm_min_ff      <= pwm_min_in;
         speed_target_ff <= speed_target_in;
         map_gain_ff     <= map_gain_in;
         acc_ff          <= acc_in;
         last_err_ff     <= last_err_in;
         duty_ff         <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      closed_ff <= closed_in;
      prod_ff   <= prod_in;
      speed_ff  <= speed_in;
      err_ff    <= err_in;
      prop_ff   <= prop_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      sum_ff    <= sum_in;
      trunc_ff  <= trunc_in;
   end

   assign status.closed = closed_ff;
   assign status.duty   = duty_ff;
   assign status.speed  = speed_ff;

endmodule
`default_nettype wire

// ----- rtl/bldc_speed_pi_controller.sv -----
// Top level: microcode sequencer, control store, datapath and result register.
// An accepted word runs the map and speed steps, in closed loop also the PI steps, then the
// output step, which waits for a free output register. The step counter walks the
// control store once per word; the single multiplier is used thrice in closed loop.
// A finished result waits in the output register while the next word is taken.
// Synchronous reset loads the register defaults and clears the integral, previous error and duty.
`timescale 1ns / 1ps
`default_nettype none
module bldc_speed_pi_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // period[15:0]
   input  logic        req_tuser,   // closed_loop[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pwm_duty[15:0], speed_mapped[31:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   bspc_pkg::upc_type    upc_ff, upc_in;
   bspc_pkg::ctrl_type   ctrl;
   bspc_pkg::status_type status;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic                 req_accept;
   logic                 out_free;

   bspc_rom u_rom (
      .upc  (upc_ff),
      .ctrl (ctrl)
   );

   bspc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_accept (req_accept),
      .req_period (req_tdata),
      .req_closed (req_tuser),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status)
   );

   assign req_tready = (ctrl.cond == bspc_pkg::C_WAIT_IN);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      unique case (ctrl.cond)
         bspc_pkg::C_NEXT:     upc_in = upc_ff + 4'd1;
         bspc_pkg::C_WAIT_IN:  upc_in = req_accept ? upc_ff + 4'd1 : upc_ff;
         bspc_pkg::C_OPEN:     upc_in = status.closed ? upc_ff + 4'd1 : ctrl.target;
         bspc_pkg::C_WAIT_OUT: upc_in = out_free ? ctrl.target : upc_ff;
         bspc_pkg::C_JUMP:     upc_in = ctrl.target;
         default:              upc_in = bspc_pkg::STEP_FETCH;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((ctrl.op == bspc_pkg::OP_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {status.speed, status.duty};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= bspc_pkg::STEP_FETCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- rtl/bspc_checker.sv -----
// Port-level checks of the speed PI controller and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bspc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Only one word is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again while a word is in work");

   // A result never appears right after an accept.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared one cycle after an accept");

endmodule

bind bldc_speed_pi_controller bspc_checker u_bspc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
